>>> design/pidl_pkg.sv
// Shared types, sizes and codes for the positional insert/delete list.
package pidl_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int COUNT_W = 6;
  localparam int STATUS_W = 3;
  localparam int OP_W = 2;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic start;
    logic emit;
  } pidl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic trav_more;
    logic trav_last;
  } pidl_stat_t;

endpackage

>>> design/pidl_ctrl.sv
// Controller state machine that sequences word acceptance and traversal.
module pidl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pidl_pkg::pidl_stat_t stat,
  output pidl_pkg::pidl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TRAV = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready = 1'b0;
    cmd.start = 1'b0;
    cmd.emit = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        cmd.start = in_valid && stat.out_free;
        if (cmd.start && stat.trav_more) begin
          state_next = S_TRAV;
        end
      end
      S_TRAV: begin
        cmd.emit = stat.out_free;
        if (cmd.emit && stat.trav_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/pidl_datapath.sv
// Datapath with the shifting entry row, entry count, traversal index and result register.
module pidl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pidl_pkg::pidl_cmd_t                  cmd,
  output pidl_pkg::pidl_stat_t                 stat,
  input  logic [pidl_pkg::OP_W-1:0]            op,
  input  logic [pidl_pkg::POS_W-1:0]           position,
  input  logic signed [pidl_pkg::VAL_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidl_pkg::VAL_W-1:0]    value_res,
  output logic                                 last,
  output logic [pidl_pkg::STATUS_W-1:0]        status,
  output logic [pidl_pkg::COUNT_W-1:0]         count
);

  logic signed [pidl_pkg::VAL_W-1:0] entries [pidl_pkg::CAPACITY];
  logic [pidl_pkg::CNT_W-1:0] entry_count;
  logic [pidl_pkg::CNT_W-1:0] entry_count_next;
  logic [pidl_pkg::CNT_W-1:0] idx;
  logic [pidl_pkg::CMP_W-1:0] pos_ext;
  logic [pidl_pkg::CMP_W-1:0] cnt_ext;
  logic [pidl_pkg::STATUS_W-1:0] start_status;
  logic do_ins;
  logic do_del;
  logic trav_ok;

  assign pos_ext = pidl_pkg::CMP_W'(position);
  assign cnt_ext = pidl_pkg::CMP_W'(entry_count);

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    trav_ok = 1'b0;
    start_status = pidl_pkg::ST_OK;
    entry_count_next = entry_count;
    case (op)
      pidl_pkg::OP_INSERT: begin
        if (cnt_ext >= pidl_pkg::CMP_W'(pidl_pkg::CAPACITY)) begin
          start_status = pidl_pkg::ST_OVERFLOW;
        end else if (pos_ext > cnt_ext) begin
          start_status = pidl_pkg::ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          entry_count_next = entry_count + pidl_pkg::CNT_W'(1);
        end
      end
      pidl_pkg::OP_DELETE: begin
        if (entry_count == '0) begin
          start_status = pidl_pkg::ST_UNDERFLOW;
        end else if (pos_ext >= cnt_ext) begin
          start_status = pidl_pkg::ST_BADPOS;
        end else begin
          do_del = 1'b1;
          entry_count_next = entry_count - pidl_pkg::CNT_W'(1);
        end
      end
      pidl_pkg::OP_TRAVERSE: begin
        if (entry_count == '0) begin
          start_status = pidl_pkg::ST_EMPTY;
        end else begin
          trav_ok = 1'b1;
        end
      end
      default: begin
        start_status = pidl_pkg::ST_BADPOS;
      end
    endcase
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.trav_more = (op == pidl_pkg::OP_TRAVERSE) && (entry_count > pidl_pkg::CNT_W'(1));
  assign stat.trav_last = (pidl_pkg::CNT_W'(idx + pidl_pkg::CNT_W'(1)) == entry_count);

  always_ff @(posedge clk) begin
    for (int i = 0; i < pidl_pkg::CAPACITY; i++) begin
      if (cmd.start && do_ins) begin
        if (pidl_pkg::CMP_W'(i) == pos_ext) begin
          entries[i] <= value;
        end else if (pidl_pkg::CMP_W'(i) > pos_ext && i > 0) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.start && do_del) begin
        if (pidl_pkg::CMP_W'(i) >= pos_ext && i < pidl_pkg::CAPACITY - 1) begin
          entries[i] <= entries[(i < pidl_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      last <= trav_ok ? (entry_count == pidl_pkg::CNT_W'(1)) : 1'b1;
      value_res <= trav_ok ? entries[0] : '0;
      status <= start_status;
      count <= pidl_pkg::COUNT_W'(entry_count_next);
    end else if (cmd.emit) begin
      last <= stat.trav_last;
      value_res <= entries[idx[pidl_pkg::IDX_W-1:0]];
      status <= pidl_pkg::ST_OK;
      count <= pidl_pkg::COUNT_W'(entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      entry_count <= '0;
      idx <= '0;
    end else begin
      if (cmd.start || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.start) begin
        entry_count <= entry_count_next;
        idx <= pidl_pkg::CNT_W'(1);
      end else if (cmd.emit) begin
        idx <= idx + pidl_pkg::CNT_W'(1);
      end
    end
  end

endmodule

>>> design/positional_insert_delete_list.sv
// Top level of the positional insert/delete list of signed 32-bit words.
//
//   Channel  Handshake            Words carried
//   input    in_valid/in_ready    op, position, value
//   output   out_valid/out_ready  value_res, last, status, count
//
// Insert, delete and error requests each give one word.
// A traverse gives one word per stored entry, one per cycle while the output is free, read from the register row.
// Input is held off while a traverse is still emitting entries.
// A finished word that waits in the output register holds off the next request until taken.
// Reset clears the count and the handshake state; entries stay unknown until written.
module positional_insert_delete_list (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pidl_pkg::OP_W-1:0]            op,
  input  logic [pidl_pkg::POS_W-1:0]           position,
  input  logic signed [pidl_pkg::VAL_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pidl_pkg::VAL_W-1:0]    value_res,
  output logic                                 last,
  output logic [pidl_pkg::STATUS_W-1:0]        status,
  output logic [pidl_pkg::COUNT_W-1:0]         count
);

  pidl_pkg::pidl_cmd_t cmd;
  pidl_pkg::pidl_stat_t stat;

  pidl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last      (last),
    .status    (status),
    .count     (count)
  );

endmodule
